// ===== sv/obp_pkg.sv =====
// Shared types, constants and width helpers for the oscillometric BP detector.
// No dependencies; all other files but obp_fifo refer to this package by scoped names.
package obp_pkg;

   localparam int SAMPLE_W  = 12;  // cuff sample, mV
   localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
   localparam int OUT_W     = 9;   // mmHg result, two's complement
   localparam int CSR_IDX_W = 2;   // register index on the CSR channel
   localparam int CSR_W     = 12;  // CSR data width

   // CSR reset values
   localparam int THRESHOLD_RESET         = 10;
   localparam int DIASTOLIC_DEFAULT_RESET = 2000;

   // mV sum to mmHg conversion, Q16
   localparam int MV_TO_MMHG_Q16 = 5988;
   localparam int OFFSET_Q16     = 75 * 65536;
   localparam int HALF_Q16       = 32768;
   localparam int OUT_MIN        = -74;
   localparam int OUT_MAX        = 227;
   localparam int QUOT_W         = 12;  // short sum / window length never exceeds 4095
   localparam int FRAC_W         = 13;  // fractional table entries stay below 5988
   localparam int Q_W            = 27;  // signed Q16 working value

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OSC_THRESHOLD     = 2'd0,
      REG_DIASTOLIC_DEFAULT = 2'd1
   } obp_reg_type;

   // Per-item tag that travels with the running sums
   typedef struct packed {
      logic eval;  // delay line full, center is evaluated
      logic last;  // final sample of the record
   } obp_tag_type;

   typedef struct packed {
      logic systolic;
      logic diastolic;
   } obp_found_type;

   // Bits needed for a sum of len full-scale samples
   function automatic int sum_w(input int len);
      return $clog2(SAMPLE_MAX * len + 1);
   endfunction

endpackage

// ===== sv/obp_intf.sv =====
// Channel interfaces for the BP detector: sample input, result output, CSR writes.
// Depends on obp_pkg for payload widths.
interface obp_req_if;
   logic                         valid;
   logic                         ready;
   logic [obp_pkg::SAMPLE_W-1:0] sample_mv;
   logic                         last;
   modport source (output valid, sample_mv, last, input ready);
   modport sink   (input valid, sample_mv, last, output ready);
endinterface

interface obp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [obp_pkg::OUT_W-1:0] systolic_mmhg;
   logic signed [obp_pkg::OUT_W-1:0] diastolic_mmhg;
   logic                             systolic_found;
   logic                             diastolic_found;
   modport source (output valid, systolic_mmhg, diastolic_mmhg, systolic_found,
                   diastolic_found, input ready);
   modport sink   (input valid, systolic_mmhg, diastolic_mmhg, systolic_found,
                   diastolic_found, output ready);
endinterface

interface obp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [obp_pkg::CSR_IDX_W-1:0] index;
   logic [obp_pkg::CSR_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/obp_fifo.sv =====
// Small register queue between the front and back halves of the detector.
// Depends on nothing but its parameters.
module obp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/obp_front.sv =====
// Front half: sample delay line, centered short and long running sums, fill count.
// Depends on obp_pkg and obp_req_if; hands one tagged sum pair per item to the queue.
module obp_front #(
   parameter int HALF_WINDOW = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   obp_req_if.sink              req_bus,
   input  logic                 full,
   output logic                 push,
   output obp_pkg::obp_tag_type tag,
   output logic [obp_pkg::sum_w(2*HALF_WINDOW+1)-1:0] short_sum,
   output logic [obp_pkg::sum_w(4*HALF_WINDOW+1)-1:0] long_sum
);

   localparam int LINE_LEN  = 4 * HALF_WINDOW + 1;
   localparam int SHORT_LEN = 2 * HALF_WINDOW + 1;
   localparam int SSW       = obp_pkg::sum_w(SHORT_LEN);
   localparam int LSW       = obp_pkg::sum_w(LINE_LEN);
   localparam int CNT_W     = $clog2(LINE_LEN + 1);

   logic [obp_pkg::SAMPLE_W-1:0] line_ff [LINE_LEN];
   logic [SSW-1:0]               short_ff;
   logic [LSW-1:0]               long_ff;
   logic [CNT_W-1:0]             seen_ff, seen_in;
   logic                         accept;

   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && !full;
   assign push          = accept;

   // slide both windows by one sample
   always_comb begin
      short_sum = short_ff + SSW'(line_ff[HALF_WINDOW-1]) - SSW'(line_ff[3*HALF_WINDOW]);
      long_sum  = long_ff + LSW'(req_bus.sample_mv) - LSW'(line_ff[LINE_LEN-1]);
      seen_in   = (seen_ff == CNT_W'(LINE_LEN)) ? seen_ff : seen_ff + 1'b1;
      tag.eval  = (seen_in == CNT_W'(LINE_LEN));
      tag.last  = req_bus.last;
   end

   // shift the line; clear everything after the final sample of a record
   always_ff @(posedge clock) begin
      if (reset || (accept && req_bus.last)) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            line_ff[i] <= '0;
         end
         short_ff <= '0;
         long_ff  <= '0;
         seen_ff  <= '0;
      end else if (accept) begin
         line_ff[0] <= req_bus.sample_mv;
         for (int i = 1; i < LINE_LEN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
         short_ff <= short_sum;
         long_ff  <= long_sum;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== sv/obp_back.sv =====
// Back half: CSRs, oscillation classification and systolic/diastolic extreme tracking.
// Depends on obp_pkg and obp_csr_if; feeds final sums of a record to the converter.
module obp_back #(
   parameter int HALF_WINDOW = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   obp_csr_if.sink              csr_bus,
   input  logic                 in_valid,
   input  obp_pkg::obp_tag_type in_tag,
   input  logic [obp_pkg::sum_w(2*HALF_WINDOW+1)-1:0] in_short,
   input  logic [obp_pkg::sum_w(4*HALF_WINDOW+1)-1:0] in_long,
   output logic                 pop,
   input  logic                 adv,
   output logic                 out_valid,
   output logic [obp_pkg::sum_w(2*HALF_WINDOW+1)-1:0] out_sys_sum,
   output logic [obp_pkg::sum_w(2*HALF_WINDOW+1)-1:0] out_dia_sum,
   output obp_pkg::obp_found_type out_found
);

   localparam int LINE_LEN  = 4 * HALF_WINDOW + 1;
   localparam int SHORT_LEN = 2 * HALF_WINDOW + 1;
   localparam int SSW       = obp_pkg::sum_w(SHORT_LEN);
   localparam int LIM_SCALE = SHORT_LEN * LINE_LEN;
   localparam int MW        = obp_pkg::sum_w(LIM_SCALE);
   localparam int DW        = MW + 1;

   logic [MW-1:0]                lim_ff;
   logic [obp_pkg::CSR_W-1:0]    dflt_ff;

   logic                         c_valid_ff;
   obp_pkg::obp_tag_type         c_tag_ff;
   logic signed [DW-1:0]         c_diff_ff;
   logic [SSW-1:0]               c_short_ff;
   logic [DW-1:0]                scaled_short, scaled_long;

   logic [SSW-1:0]               best_sys_ff, best_sys_in;
   logic [SSW-1:0]               low_dia_ff, low_dia_in;
   obp_pkg::obp_found_type       found_ff, found_in;
   logic signed [DW-1:0]         lim_s;
   logic                         at_sys, at_dia;

   logic                         v_valid_ff;
   logic [SSW-1:0]               v_sys_ff, v_dia_ff;
   obp_pkg::obp_found_type       v_found_ff;

   // register writes; the threshold is kept pre-scaled for the cross-multiply
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff  <= MW'(obp_pkg::THRESHOLD_RESET * LIM_SCALE);
         dflt_ff <= obp_pkg::CSR_W'(obp_pkg::DIASTOLIC_DEFAULT_RESET);
      end else if (csr_bus.valid) begin
         unique case (obp_pkg::obp_reg_type'(csr_bus.index))
            obp_pkg::REG_OSC_THRESHOLD: begin
               lim_ff <= MW'(csr_bus.data) * MW'(LIM_SCALE);
            end
            obp_pkg::REG_DIASTOLIC_DEFAULT: begin
               dflt_ff <= csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   // classify stage: short*LINE_LEN - long*SHORT_LEN
   assign pop          = adv && in_valid;
   assign scaled_short = DW'(in_short) * DW'(LINE_LEN);
   assign scaled_long  = DW'(in_long) * DW'(SHORT_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_tag_ff   <= in_tag;
         c_short_ff <= in_short;
         c_diff_ff  <= $signed(scaled_short - scaled_long);
      end
   end

   // track stage: systolic test first, diastolic only when it fails
   always_comb begin
      lim_s        = $signed({1'b0, lim_ff});
      at_sys       = c_valid_ff && c_tag_ff.eval && (c_diff_ff >= lim_s);
      at_dia       = c_valid_ff && c_tag_ff.eval && !(c_diff_ff >= lim_s) &&
                     (c_diff_ff <= -lim_s);
      best_sys_in  = (at_sys && (c_short_ff > best_sys_ff)) ? c_short_ff : best_sys_ff;
      low_dia_in   = (at_dia && (c_short_ff < low_dia_ff)) ? c_short_ff : low_dia_ff;
      found_in.systolic  = found_ff.systolic || at_sys;
      found_in.diastolic = found_ff.diastolic || at_dia;
   end

   // update extremes; hand them over and clear at the end of a record
   always_ff @(posedge clock) begin
      if (reset) begin
         best_sys_ff <= '0;
         low_dia_ff  <= SSW'(obp_pkg::DIASTOLIC_DEFAULT_RESET * SHORT_LEN);
         found_ff    <= '0;
         v_valid_ff  <= 1'b0;
      end else if (adv) begin
         v_valid_ff <= c_valid_ff && c_tag_ff.last;
         if (c_valid_ff && c_tag_ff.last) begin
            best_sys_ff <= '0;
            low_dia_ff  <= SSW'(dflt_ff) * SSW'(SHORT_LEN);
            found_ff    <= '0;
         end else begin
            best_sys_ff <= best_sys_in;
            low_dia_ff  <= low_dia_in;
            found_ff    <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && c_valid_ff && c_tag_ff.last) begin
         v_sys_ff   <= best_sys_in;
         v_dia_ff   <= low_dia_in;
         v_found_ff <= found_in;
      end
   end

   assign out_valid   = v_valid_ff;
   assign out_sys_sum = v_sys_ff;
   assign out_dia_sum = v_dia_ff;
   assign out_found   = v_found_ff;

endmodule

// ===== sv/obp_conv.sv =====
// Converter: short-window sums to saturated mmHg, three pipeline stages, result register.
// Depends on obp_pkg and obp_rsp_if; division by the window length uses a reciprocal.
module obp_conv #(
   parameter int HALF_WINDOW = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [obp_pkg::sum_w(2*HALF_WINDOW+1)-1:0] in_sys_sum,
   input  logic [obp_pkg::sum_w(2*HALF_WINDOW+1)-1:0] in_dia_sum,
   input  obp_pkg::obp_found_type in_found,
   output logic                   adv,
   obp_rsp_if.source              rsp_bus
);

   localparam int SHORT_LEN = 2 * HALF_WINDOW + 1;
   localparam int SSW       = obp_pkg::sum_w(SHORT_LEN);
   localparam int RL        = $clog2(SHORT_LEN);
   localparam int SHIFT     = SSW + RL;
   localparam int RECIP     = ((1 << SHIFT) + SHORT_LEN - 1) / SHORT_LEN;
   localparam int RECIP_W   = SSW + 2;
   localparam int PROD_W    = SSW + RECIP_W;
   localparam int QW        = obp_pkg::Q_W;
   localparam int RW        = QW - 15;
   localparam logic signed [RW-1:0] R_MIN = RW'(obp_pkg::OUT_MIN);
   localparam logic signed [RW-1:0] R_MAX = RW'(obp_pkg::OUT_MAX);

   // Q16 value of floor(r * 5988 / SHORT_LEN) for each remainder r
   logic [obp_pkg::FRAC_W-1:0] frac_tab [2**RL];

   for (genvar i = 0; i < 2**RL; i++) begin : g_frac
      localparam int Frac = (i < SHORT_LEN) ? (i * obp_pkg::MV_TO_MMHG_Q16) / SHORT_LEN : 0;
      assign frac_tab[i] = obp_pkg::FRAC_W'(Frac);
   end

   // lane 0 systolic, lane 1 diastolic
   logic                           s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   obp_pkg::obp_found_type         s1_found_ff, s2_found_ff, s3_found_ff, out_found_ff;
   logic [SSW-1:0]                 s1_sum_ff  [2];
   logic [PROD_W-1:0]              s1_prod_ff [2];
   logic [obp_pkg::QUOT_W-1:0]     s2_quot_ff [2];
   logic [RL-1:0]                  s2_rem_ff  [2];
   logic signed [QW-1:0]           s3_q_ff    [2];
   logic signed [obp_pkg::OUT_W-1:0] out_mmhg_ff [2];
   logic [SSW-1:0]                 in_sum     [2];
   logic [obp_pkg::QUOT_W-1:0]     quot_in    [2];

   // round via +0.5 then truncate toward zero, saturate
   function automatic logic signed [obp_pkg::OUT_W-1:0] to_mmhg(
      input logic signed [QW-1:0] q
   );
      logic [QW-1:0]        mag;
      logic signed [RW-1:0] r;
      mag = q[QW-1] ? QW'(-q) : QW'(q);
      r   = q[QW-1] ? -$signed({1'b0, mag[QW-1:16]}) : $signed({1'b0, mag[QW-1:16]});
      if (r < R_MIN) begin
         r = R_MIN;
      end else if (r > R_MAX) begin
         r = R_MAX;
      end
      return obp_pkg::OUT_W'(r);
   endfunction

   assign adv       = !out_valid_ff || rsp_bus.ready;
   assign in_sum[0] = in_sys_sum;
   assign in_sum[1] = in_dia_sum;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         quot_in[l] = obp_pkg::QUOT_W'(s1_prod_ff[l] >> SHIFT);
      end
   end

   // hold all stages while the result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_found_ff  <= in_found;
         s2_found_ff  <= s1_found_ff;
         s3_found_ff  <= s2_found_ff;
         out_found_ff <= s3_found_ff;
         for (int l = 0; l < 2; l++) begin
            // reciprocal multiply
            s1_sum_ff[l]  <= in_sum[l];
            s1_prod_ff[l] <= PROD_W'(in_sum[l]) * PROD_W'(RECIP);
            // quotient and remainder of the window length
            s2_quot_ff[l] <= quot_in[l];
            s2_rem_ff[l]  <= RL'(s1_sum_ff[l] - SSW'(quot_in[l]) * SSW'(SHORT_LEN));
            // Q16 value less the offset, plus one half
            s3_q_ff[l]    <= $signed(QW'(s2_quot_ff[l]) * QW'(obp_pkg::MV_TO_MMHG_Q16)
                             + QW'(frac_tab[s2_rem_ff[l]])
                             - QW'(obp_pkg::OFFSET_Q16 - obp_pkg::HALF_Q16));
            out_mmhg_ff[l] <= to_mmhg(s3_q_ff[l]);
         end
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.systolic_mmhg   = out_mmhg_ff[0];
   assign rsp_bus.diastolic_mmhg  = out_mmhg_ff[1];
   assign rsp_bus.systolic_found  = out_found_ff.systolic;
   assign rsp_bus.diastolic_found = out_found_ff.diastolic;

endmodule

// ===== sv/oscillometric_bp_detector.sv =====
// Oscillometric BP detector: takes one sample per cycle unless the queue is full; a
// record's result passes the queue, classify, track, three conversion stages and the
// result register. Throughput is one item per cycle while the result side does not
// stall, set by the running-sum update in the front. Synchronous active-high reset
// clears the delay line, sums and extremes and loads threshold 10 mV, default 2000 mV.
// Depends on obp_pkg, obp_intf, obp_fifo, obp_front, obp_back, obp_conv.
module oscillometric_bp_detector #(
   parameter int HALF_WINDOW = 10
) (
   input  logic       clock,
   input  logic       reset,
   obp_req_if.sink    req_bus,
   obp_rsp_if.source  rsp_bus,
   obp_csr_if.sink    csr_bus
);

   localparam int SSW = obp_pkg::sum_w(2 * HALF_WINDOW + 1);
   localparam int LSW = obp_pkg::sum_w(4 * HALF_WINDOW + 1);
   localparam int TAG_W = $bits(obp_pkg::obp_tag_type);
   localparam int Q_DW  = TAG_W + SSW + LSW;

   logic                   push, full, pop, empty, adv;
   obp_pkg::obp_tag_type   f_tag, b_tag;
   logic [SSW-1:0]         f_short, b_short;
   logic [LSW-1:0]         f_long, b_long;
   logic [Q_DW-1:0]        q_out;
   logic                   v_valid;
   logic [SSW-1:0]         v_sys, v_dia;
   obp_pkg::obp_found_type v_found;

   obp_front #(.HALF_WINDOW(HALF_WINDOW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .full      (full),
      .push      (push),
      .tag       (f_tag),
      .short_sum (f_short),
      .long_sum  (f_long)
   );

   obp_fifo #(.WIDTH(Q_DW), .DEPTH(obp_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_tag, f_short, f_long}),
      .full      (full),
      .pop       (pop),
      .pop_data  (q_out),
      .empty     (empty)
   );

   assign b_tag   = obp_pkg::obp_tag_type'(q_out[Q_DW-1 -: TAG_W]);
   assign b_short = q_out[LSW +: SSW];
   assign b_long  = q_out[LSW-1:0];

   obp_back #(.HALF_WINDOW(HALF_WINDOW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_bus     (csr_bus),
      .in_valid    (!empty),
      .in_tag      (b_tag),
      .in_short    (b_short),
      .in_long     (b_long),
      .pop         (pop),
      .adv         (adv),
      .out_valid   (v_valid),
      .out_sys_sum (v_sys),
      .out_dia_sum (v_dia),
      .out_found   (v_found)
   );

   obp_conv #(.HALF_WINDOW(HALF_WINDOW)) u_conv (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v_valid),
      .in_sys_sum (v_sys),
      .in_dia_sum (v_dia),
      .in_found   (v_found),
      .adv        (adv),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== test/tb_oscillometric_bp_detector.sv =====
// Self-checking bench for oscillometric_bp_detector: directed records, then random records.
// Checks each reading against an in-bench pressure tracker or a directed expectation; needs obp_pkg and obp_intf.
`timescale 1ns / 1ps

module tb_oscillometric_bp_detector;

   localparam int HALF_WINDOW = 10;
   localparam int LINE_LEN    = 4 * HALF_WINDOW + 1;
   localparam int SHORT_LEN   = 2 * HALF_WINDOW + 1;
   localparam int CONV_Q16    = 5988;
   localparam int OFS_Q16     = 75 * 65536;
   localparam int ROUND_Q16   = 32768;
   localparam int MMHG_MIN    = -74;
   localparam int MMHG_MAX    = 227;
   localparam int SETTLE      = 20;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int QUIET_ITEMS    = 1100;

   // indexes past the register list, which the block must ignore
   localparam logic [obp_pkg::CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [obp_pkg::CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct {
      logic signed [8:0] systolic;
      logic signed [8:0] diastolic;
      logic              sys_found;
      logic              dia_found;
   } reading_type;

   typedef struct {
      logic [11:0] mv;
      int          count;
      bit          fin;
      bit          typed;
      reading_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   obp_req_if req_bus ();
   obp_rsp_if rsp_bus ();
   obp_csr_if csr_bus ();

   oscillometric_bp_detector #(
      .HALF_WINDOW (HALF_WINDOW)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // pressure tracker state
   int       delay_line [LINE_LEN];
   int       short_sum;
   int       long_sum;
   int       seen_count;
   int       best_sys_sum;
   int       low_dia_sum;
   bit       sys_hit;
   bit       dia_hit;
   int       threshold_mv;
   int       dia_default_mv;

   reading_type  expected_readings [$];
   plan_row_type directed_plan [$];
   logic [11:0]  record_q [$];
   int           fails;
   int           random_items;
   bit           quiet;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // limit on total run time
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic signed [8:0] sum_to_mmhg(input int sum);
      longint q;
      longint r;
      q = (longint'(sum) * CONV_Q16) / SHORT_LEN;
      q = q - OFS_Q16 + ROUND_Q16;
      r = q / 65536;
      if (r < MMHG_MIN) r = MMHG_MIN;
      if (r > MMHG_MAX) r = MMHG_MAX;
      return r[8:0];
   endfunction

   task automatic clear_tracker();
      foreach (delay_line[i]) delay_line[i] = 0;
      short_sum    = 0;
      long_sum     = 0;
      seen_count   = 0;
      best_sys_sum = 0;
      low_dia_sum  = SHORT_LEN * dia_default_mv;
      sys_hit      = 1'b0;
      dia_hit      = 1'b0;
   endtask

   // advance the tracker by one sample; a last sample yields a reading
   task automatic track_sample(input logic [11:0] mv, input bit fin,
                               output reading_type r, output bit made);
      longint diff;
      longint lim;
      short_sum = short_sum + delay_line[HALF_WINDOW-1] - delay_line[3*HALF_WINDOW];
      long_sum  = long_sum + int'(mv) - delay_line[LINE_LEN-1];
      for (int i = LINE_LEN - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = int'(mv);
      if (seen_count < LINE_LEN) seen_count++;
      if (seen_count >= LINE_LEN) begin
         diff = longint'(short_sum) * LINE_LEN - longint'(long_sum) * SHORT_LEN;
         lim  = longint'(threshold_mv) * SHORT_LEN * LINE_LEN;
         if (diff >= lim) begin
            if (short_sum > best_sys_sum) best_sys_sum = short_sum;
            sys_hit = 1'b1;
         end else if (diff <= -lim) begin
            if (short_sum < low_dia_sum) low_dia_sum = short_sum;
            dia_hit = 1'b1;
         end
      end
      made = fin;
      r.systolic  = sum_to_mmhg(best_sys_sum);
      r.diastolic = sum_to_mmhg(low_dia_sum);
      r.sys_found = sys_hit;
      r.dia_found = dia_hit;
      if (fin) clear_tracker();
   endtask

   // send one item, with a random gap ahead of it unless the run is quiet
   task automatic push_sample(input logic [11:0] mv, input bit fin,
                              output reading_type r, output bit made);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.sample_mv <= mv;
      req_bus.last      <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_sample(mv, fin, r, made);
   endtask

   task automatic write_csr(input logic [obp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [11:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == obp_pkg::REG_OSC_THRESHOLD) threshold_mv = int'(val);
      else if (idx == obp_pkg::REG_DIASTOLIC_DEFAULT) dia_default_mv = int'(val);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // drain outstanding readings, then let the pipeline settle
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_row(input logic [11:0] mv, input int count, input bit fin,
                          input bit typed = 1'b0, input int sys = 0, input int dia = 0,
                          input bit sf = 1'b0, input bit df = 1'b0);
      plan_row_type row;
      row.mv    = mv;
      row.count = count;
      row.fin   = fin;
      row.typed = typed;
      row.want.systolic  = sys[8:0];
      row.want.diastolic = dia[8:0];
      row.want.sys_found = sf;
      row.want.dia_found = df;
      directed_plan.insert(directed_plan.size(), row);
   endtask

   // shape one random measurement record
   task automatic build_record();
      int kind;
      int len;
      int base;
      int drop;
      int amp;
      int period;
      int ph;
      int tri_v;
      int v;
      int level;
      record_q.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         // deflating cuff with pulse ripple and a little noise
         len    = $urandom_range(41, 90);
         base   = $urandom_range(800, 3000);
         drop   = $urandom_range(0, 800);
         amp    = $urandom_range(0, 400);
         period = $urandom_range(6, 30);
         for (int i = 0; i < len; i++) begin
            ph    = i % period;
            tri_v = (ph < period / 2) ? ph : period - ph;
            v = base - drop * i / len + amp * (2 * tri_v - period / 2) / (period / 2)
                + $urandom_range(0, 20) - 10;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            record_q.insert(record_q.size(), v[11:0]);
         end
      end else if (kind <= 5) begin
         len = $urandom_range(41, 70);
         for (int i = 0; i < len; i++)
            record_q.insert(record_q.size(), 12'($urandom_range(0, 4095)));
      end else if (kind == 6) begin
         len   = $urandom_range(41, 60);
         level = $urandom_range(0, 4095);
         for (int i = 0; i < len; i++) record_q.insert(record_q.size(), level[11:0]);
      end else if (kind <= 8) begin
         len = $urandom_range(1, 40);
         for (int i = 0; i < len; i++)
            record_q.insert(record_q.size(), 12'($urandom_range(0, 4095)));
      end else begin
         // blocks of steady level
         len   = $urandom_range(41, 100);
         level = $urandom_range(0, 4095);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 14) == 0) level = $urandom_range(0, 4095);
            record_q.insert(record_q.size(), level[11:0]);
         end
      end
   endtask

   // result side: random stall bursts, none once the run goes quiet
   initial begin : rsp_stall
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         n = $urandom_range(1, 24);
         repeat (n) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
         if (!quiet) begin
            n = $urandom_range(1, 11);
            repeat (n) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   // compare each accepted reading with the oldest expectation
   always @(posedge clock) begin : rsp_check
      reading_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: reading with none expected: sys %0d dia %0d found %b%b", $time,
                     rsp_bus.systolic_mmhg, rsp_bus.diastolic_mmhg,
                     rsp_bus.systolic_found, rsp_bus.diastolic_found);
            fails++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_bus.systolic_mmhg !== want.systolic) begin
               $display("%0t: systolic_mmhg expected %0d got %0d", $time,
                        want.systolic, rsp_bus.systolic_mmhg);
               fails++;
            end
            if (rsp_bus.diastolic_mmhg !== want.diastolic) begin
               $display("%0t: diastolic_mmhg expected %0d got %0d", $time,
                        want.diastolic, rsp_bus.diastolic_mmhg);
               fails++;
            end
            if (rsp_bus.systolic_found !== want.sys_found) begin
               $display("%0t: systolic_found expected %b got %b", $time,
                        want.sys_found, rsp_bus.systolic_found);
               fails++;
            end
            if (rsp_bus.diastolic_found !== want.dia_found) begin
               $display("%0t: diastolic_found expected %b got %b", $time,
                        want.dia_found, rsp_bus.diastolic_found);
               fails++;
            end
         end
      end
   end

   initial begin : stimulus
      reading_type  r;
      bit           made;
      int           phase_no;
      int           records_in_phase;
      plan_row_type row;

      fails          = 0;
      random_items   = 0;
      quiet          = 1'b0;
      reset          = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample_mv = '0;
      req_bus.last      = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = obp_pkg::REG_OSC_THRESHOLD;
      csr_bus.data      = '0;
      threshold_mv      = obp_pkg::THRESHOLD_RESET;
      dia_default_mv    = obp_pkg::DIASTOLIC_DEFAULT_RESET;
      clear_tracker();

      // directed records under reset settings
      add_row(12'd0, 1, 1'b1, 1'b1, -74, 108, 1'b0, 1'b0);      // one-sample record
      add_row(12'd4095, 1, 1'b1, 1'b1, -74, 108, 1'b0, 1'b0);   // full-scale one-sample
      add_row(12'd500, 39, 1'b0);                               // one short of a full line
      add_row(12'd500, 1, 1'b1, 1'b1, -74, 108, 1'b0, 1'b0);
      add_row(12'd4095, 40, 1'b0);                              // flat: no oscillation
      add_row(12'd4095, 1, 1'b1, 1'b1, -74, 108, 1'b0, 1'b0);
      add_row(12'd0, 10, 1'b0);                                 // pulse: systolic saturates
      add_row(12'd4095, 21, 1'b0);
      add_row(12'd0, 9, 1'b0);
      add_row(12'd0, 1, 1'b1);
      add_row(12'd3300, 10, 1'b0);                              // dip: diastolic at 0 mV
      add_row(12'd0, 21, 1'b0);
      add_row(12'd3300, 9, 1'b0);
      add_row(12'd3300, 1, 1'b1);
      add_row(12'd2730, 30, 1'b0);                              // longer record, step down
      add_row(12'd1365, 30, 1'b0);
      add_row(12'd3000, 1, 1'b1);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (directed_plan.size() != 0) begin
         row = directed_plan.pop_front();
         repeat (row.count) begin
            push_sample(row.mv, row.fin, r, made);
            if (made)
               expected_readings.insert(expected_readings.size(), row.typed ? row.want : r);
         end
      end

      // random records over a series of register settings
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_drained();
         unique case (phase_no)
            0: begin
               write_csr(obp_pkg::REG_OSC_THRESHOLD, 12'd0);
               write_csr(obp_pkg::REG_DIASTOLIC_DEFAULT, 12'd0);
            end
            1: begin
               write_csr(obp_pkg::REG_OSC_THRESHOLD, 12'd3300);
               write_csr(obp_pkg::REG_DIASTOLIC_DEFAULT, 12'd3300);
            end
            2: begin
               write_csr(obp_pkg::REG_OSC_THRESHOLD, 12'd4095);
               write_csr(obp_pkg::REG_DIASTOLIC_DEFAULT, 12'd4095);
               write_csr(REG_SPARE_A, 12'd1);
               write_csr(REG_SPARE_B, 12'd4095);
            end
            default: begin
               if ($urandom_range(0, 3) == 0)
                  write_csr(obp_pkg::REG_OSC_THRESHOLD, 12'($urandom_range(0, 4095)));
               else
                  write_csr(obp_pkg::REG_OSC_THRESHOLD, 12'($urandom_range(0, 60)));
               write_csr(obp_pkg::REG_DIASTOLIC_DEFAULT, 12'($urandom_range(0, 4095)));
            end
         endcase
         phase_no++;

         records_in_phase = $urandom_range(4, 8);
         repeat (records_in_phase) begin
            if (random_items < RANDOM_ITEMS) begin
               build_record();
               foreach (record_q[i]) begin
                  push_sample(record_q[i], i == record_q.size() - 1, r, made);
                  if (made) expected_readings.insert(expected_readings.size(), r);
                  random_items++;
                  if (random_items >= QUIET_ITEMS) quiet = 1'b1;
               end
            end
         end
      end

      wait_drained();
      if (fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
